>>> hw/rtl/sc2h_pkg.sv
// Package for the Set 2 scan code to HID usage translator.
// Holds the prefix state type, the scan byte codes, the result struct and the usage ROM.
// No dependencies.
package sc2h_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PageW  = 4;
  localparam int unsigned IdW    = 12;
  localparam int unsigned UsageW = PageW + IdW;

  localparam logic [ByteW-1:0] CODE_E0      = 8'hE0;
  localparam logic [ByteW-1:0] CODE_F0      = 8'hF0;
  localparam logic [ByteW-1:0] CODE_E1      = 8'hE1;
  localparam logic [ByteW-1:0] CODE_F7      = 8'h83;
  localparam logic [ByteW-1:0] CODE_SYSRQ   = 8'h84;
  localparam logic [ByteW-1:0] CODE_KOR_1   = 8'hF1;
  localparam logic [ByteW-1:0] CODE_KOR_2   = 8'hF2;
  localparam logic [ByteW-1:0] CODE_LSHIFT  = 8'h12;
  localparam logic [ByteW-1:0] CODE_RSHIFT  = 8'h59;
  localparam logic [ByteW-1:0] CODE_LCTRL   = 8'h14;
  localparam logic [ByteW-1:0] CODE_NUMLK   = 8'h77;
  localparam logic [ByteW-1:0] CODE_EXT_BIT = 8'h80;

  typedef enum logic [3:0] {
    ST_IDLE        = 4'd0,
    ST_F0          = 4'd1,
    ST_E0          = 4'd2,
    ST_E0_F0       = 4'd3,
    ST_E1          = 4'd4,
    ST_E1_14       = 4'd5,
    ST_E1_F0       = 4'd6,
    ST_E1_F0_14    = 4'd7,
    ST_E1_F0_14_F0 = 4'd8
  } prefix_state_t;

  typedef struct packed {
    logic             event_valid;
    logic             is_make;
    logic [PageW-1:0] usage_page;
    logic [IdW-1:0]   usage_id;
    logic             decode_error;
  } key_result_t;

  function automatic logic [UsageW-1:0] usage_rom(input logic [ByteW-1:0] idx);
    logic [UsageW-1:0] w;
    unique case (idx)
      8'h01: w = 16'h0042;  8'h03: w = 16'h003E;  8'h04: w = 16'h003C;
      8'h05: w = 16'h003A;  8'h06: w = 16'h003B;  8'h07: w = 16'h0045;
      8'h08: w = 16'h0068;  8'h09: w = 16'h0043;  8'h0A: w = 16'h0041;
      8'h0B: w = 16'h003F;  8'h0C: w = 16'h003D;  8'h0D: w = 16'h002B;
      8'h0E: w = 16'h0035;  8'h0F: w = 16'h0067;
      8'h10: w = 16'h0069;  8'h11: w = 16'h00E2;  8'h12: w = 16'h00E1;
      8'h13: w = 16'h0088;  8'h14: w = 16'h00E0;  8'h15: w = 16'h0014;
      8'h16: w = 16'h001E;  8'h18: w = 16'h006A;  8'h1A: w = 16'h001D;
      8'h1B: w = 16'h0016;  8'h1C: w = 16'h0004;  8'h1D: w = 16'h001A;
      8'h1E: w = 16'h001F;
      8'h20: w = 16'h006B;  8'h21: w = 16'h0006;  8'h22: w = 16'h001B;
      8'h23: w = 16'h0007;  8'h24: w = 16'h0008;  8'h25: w = 16'h0021;
      8'h26: w = 16'h0020;  8'h27: w = 16'h008C;  8'h28: w = 16'h006C;
      8'h29: w = 16'h002C;  8'h2A: w = 16'h0019;  8'h2B: w = 16'h0009;
      8'h2C: w = 16'h0017;  8'h2D: w = 16'h0015;  8'h2E: w = 16'h0022;
      8'h30: w = 16'h006D;  8'h31: w = 16'h0011;  8'h32: w = 16'h0005;
      8'h33: w = 16'h000B;  8'h34: w = 16'h000A;  8'h35: w = 16'h001C;
      8'h36: w = 16'h0023;  8'h38: w = 16'h006E;  8'h3A: w = 16'h0010;
      8'h3B: w = 16'h000D;  8'h3C: w = 16'h0018;  8'h3D: w = 16'h0024;
      8'h3E: w = 16'h0025;
      8'h40: w = 16'h006F;  8'h41: w = 16'h0036;  8'h42: w = 16'h000E;
      8'h43: w = 16'h000C;  8'h44: w = 16'h0012;  8'h45: w = 16'h0027;
      8'h46: w = 16'h0026;  8'h48: w = 16'h0070;  8'h49: w = 16'h0037;
      8'h4A: w = 16'h0038;  8'h4B: w = 16'h000F;  8'h4C: w = 16'h0033;
      8'h4D: w = 16'h0013;  8'h4E: w = 16'h002D;
      8'h50: w = 16'h0071;  8'h51: w = 16'h0087;  8'h52: w = 16'h0034;
      8'h54: w = 16'h002F;  8'h55: w = 16'h002E;  8'h57: w = 16'h0072;
      8'h58: w = 16'h0039;  8'h59: w = 16'h00E5;  8'h5A: w = 16'h0028;
      8'h5B: w = 16'h0030;  8'h5D: w = 16'h0031;  8'h5F: w = 16'h0073;
      8'h61: w = 16'h0064;  8'h62: w = 16'h0093;  8'h63: w = 16'h0092;
      8'h64: w = 16'h008A;  8'h66: w = 16'h002A;  8'h67: w = 16'h008B;
      8'h69: w = 16'h0059;  8'h6A: w = 16'h0089;  8'h6B: w = 16'h005C;
      8'h6C: w = 16'h005F;  8'h6D: w = 16'h0085;
      8'h70: w = 16'h0062;  8'h71: w = 16'h0063;  8'h72: w = 16'h005A;
      8'h73: w = 16'h005D;  8'h74: w = 16'h005E;  8'h75: w = 16'h0060;
      8'h76: w = 16'h0029;  8'h77: w = 16'h0053;  8'h78: w = 16'h0044;
      8'h79: w = 16'h0057;  8'h7A: w = 16'h005B;  8'h7B: w = 16'h0056;
      8'h7C: w = 16'h0055;  8'h7D: w = 16'h0061;  8'h7E: w = 16'h0047;
      8'h7F: w = 16'h0046;
      8'h83: w = 16'h0040;  8'h84: w = 16'h0046;
      8'h90: w = 16'hC221;  8'h91: w = 16'h00E6;  8'h94: w = 16'h00E4;
      8'h95: w = 16'hC0B6;  8'h98: w = 16'hC22A;  8'h9F: w = 16'h00E3;
      8'hA0: w = 16'hC227;  8'hA1: w = 16'hC0EA;  8'hA3: w = 16'hC0E2;
      8'hA7: w = 16'h00E7;  8'hA8: w = 16'hC226;  8'hAB: w = 16'hC192;
      8'hAF: w = 16'h0065;
      8'hB0: w = 16'hC225;  8'hB2: w = 16'hC0E9;  8'hB4: w = 16'hC0CD;
      8'hB7: w = 16'h1081;  8'hB8: w = 16'hC224;  8'hBA: w = 16'hC223;
      8'hBB: w = 16'hC0B7;  8'hBF: w = 16'h1082;
      8'hC0: w = 16'hC194;  8'hC8: w = 16'hC18A;  8'hCA: w = 16'h0054;
      8'hCD: w = 16'hC0B5;
      8'hD0: w = 16'hC183;  8'hDA: w = 16'h0058;  8'hDE: w = 16'h1083;
      8'hE9: w = 16'h004D;  8'hEB: w = 16'h0050;  8'hEC: w = 16'h004A;
      8'hF0: w = 16'h0049;  8'hF1: w = 16'h004C;  8'hF2: w = 16'h0051;
      8'hF4: w = 16'h004F;  8'hF5: w = 16'h0052;  8'hF7: w = 16'h0048;
      8'hFA: w = 16'h004E;  8'hFC: w = 16'h0046;  8'hFD: w = 16'h004B;
      8'hFE: w = 16'h0048;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/sc2h_decode.sv
// Prefix state machine decode for one scan byte: next state and result fields.
// Purely combinational; uses sc2h_pkg for the state type, codes and usage ROM.
module sc2h_decode
  import sc2h_pkg::*;
(
  input  prefix_state_t    state_i,
  input  logic [ByteW-1:0] byte_i,
  output prefix_state_t    state_nxt_o,
  output key_result_t      result_o
);

  logic              plain;
  logic              fake_shift;
  logic              ev;
  logic              mk;
  logic              err;
  logic [ByteW-1:0]  idx;
  logic [UsageW-1:0] word;

  assign plain      = !byte_i[ByteW-1] || (byte_i == CODE_F7) || (byte_i == CODE_SYSRQ);
  assign fake_shift = (byte_i == CODE_LSHIFT) || (byte_i == CODE_RSHIFT);

  always_comb begin
    state_nxt_o = ST_IDLE;
    unique case (state_i) inside
      ST_IDLE: begin
        if (byte_i == CODE_E0) begin
          state_nxt_o = ST_E0;
        end else if (byte_i == CODE_F0) begin
          state_nxt_o = ST_F0;
        end else if (byte_i == CODE_E1) begin
          state_nxt_o = ST_E1;
        end
      end
      ST_E0: begin
        if (!fake_shift && byte_i == CODE_F0) begin
          state_nxt_o = ST_E0_F0;
        end
      end
      ST_E1: begin
        if (byte_i == CODE_LCTRL) begin
          state_nxt_o = ST_E1_14;
        end else if (byte_i == CODE_F0) begin
          state_nxt_o = ST_E1_F0;
        end
      end
      ST_E1_F0: begin
        if (byte_i == CODE_LCTRL) begin
          state_nxt_o = ST_E1_F0_14;
        end
      end
      ST_E1_F0_14: begin
        if (byte_i == CODE_F0) begin
          state_nxt_o = ST_E1_F0_14_F0;
        end
      end
      default: state_nxt_o = ST_IDLE;
    endcase
  end

  always_comb begin
    ev  = 1'b0;
    mk  = 1'b0;
    err = 1'b0;
    idx = byte_i;
    unique case (state_i) inside
      ST_IDLE: begin
        if (byte_i == CODE_E0 || byte_i == CODE_F0 || byte_i == CODE_E1) begin
          ev = 1'b0;
        end else if (plain) begin
          ev = 1'b1;
          mk = 1'b1;
        end else if (byte_i != CODE_KOR_1 && byte_i != CODE_KOR_2) begin
          err = 1'b1;
        end
      end
      ST_F0: begin
        if (plain) begin
          ev = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      ST_E0, ST_E0_F0: begin
        idx = byte_i | CODE_EXT_BIT;
        if (fake_shift) begin
          ev = 1'b0;
        end else if (state_i == ST_E0 && byte_i == CODE_F0) begin
          ev = 1'b0;
        end else if (!byte_i[ByteW-1]) begin
          ev = 1'b1;
          mk = (state_i == ST_E0);
        end else begin
          err = 1'b1;
        end
      end
      ST_E1_14: begin
        idx = CODE_NUMLK | CODE_EXT_BIT;
        ev  = (byte_i == CODE_NUMLK);
        mk  = 1'b1;
      end
      ST_E1_F0_14_F0: begin
        idx = CODE_NUMLK | CODE_EXT_BIT;
        ev  = (byte_i == CODE_NUMLK);
      end
      default: ev = 1'b0;
    endcase
  end

  assign word = usage_rom(idx);

  assign result_o.event_valid  = ev;
  assign result_o.is_make      = ev & mk;
  assign result_o.usage_page   = ev ? word[UsageW-1:IdW] : '0;
  assign result_o.usage_id     = ev ? word[IdW-1:0] : '0;
  assign result_o.decode_error = err;

endmodule

>>> hw/rtl/scan_code_set2_to_hid_translator_top.sv
// PS/2 Set 2 scan code to HID usage translator, top level.
// Instantiates sc2h_decode; uses sc2h_pkg.
//
// Each accepted scan byte produces exactly one result beat, in order. The block takes one
// byte per cycle while in_stall is low. An accepted byte is held in the input register, then
// the prefix state machine and the usage ROM lookup settle into the result register. Both
// registers advance together whenever the result side is not stalled. A stalled result holds
// the result register, and the input register still takes one more byte before in_stall
// rises. Results with usage 0 are still reported as events; E0 12 and E0 59 fake shifts,
// F1 and F2 give a beat with no event and no error.
module scan_code_set2_to_hid_translator_top
  import sc2h_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] in_scan_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_event_valid,
  output logic             out_is_make,
  output logic [PageW-1:0] out_usage_page,
  output logic [IdW-1:0]   out_usage_id,
  output logic             out_decode_error
);

  logic             in_valid_r;
  logic [ByteW-1:0] in_byte_r;
  logic             out_valid_r;
  key_result_t      res_r;
  key_result_t      res_nxt;
  prefix_state_t    state_r;
  prefix_state_t    state_nxt;
  logic             out_free;
  logic             move;
  logic             take;

  assign out_free = !out_valid_r || !out_stall;
  assign move     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign take     = in_valid && !in_stall;

  sc2h_decode u_decode (
    .state_i     (state_r),
    .byte_i      (in_byte_r),
    .state_nxt_o (state_nxt),
    .result_o    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ST_IDLE;
    end else begin
      if (take || move) begin
        in_valid_r <= take;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      if (move) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_byte_r <= in_scan_byte;
    end
    if (move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_valid  = res_r.event_valid;
  assign out_is_make      = res_r.is_make;
  assign out_usage_page   = res_r.usage_page;
  assign out_usage_id     = res_r.usage_id;
  assign out_decode_error = res_r.decode_error;

endmodule

>>> dv/sc2h_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the Set 2 scan code to HID usage translator.
// Predicts every result beat from the accepted scan bytes and compares it in order.
// Depends on sc2h_pkg for the result struct, the prefix states and the byte codes.
module sc2h_result_checker
  import sc2h_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [ByteW-1:0] in_scan_byte,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             out_event_valid,
  input  logic             out_is_make,
  input  logic [PageW-1:0] out_usage_page,
  input  logic [IdW-1:0]   out_usage_id,
  input  logic             out_decode_error,
  output int               fail_count,
  output int               pending_count
);

  logic [UsageW-1:0] usage_table [256];
  prefix_state_t     key_prefix;
  key_result_t       expected_keys [$];
  int                mismatches = 0;

  initial begin
    usage_table = '{
      16'h0000, 16'h0042, 16'h0000, 16'h003E, 16'h003C, 16'h003A, 16'h003B, 16'h0045,
      16'h0068, 16'h0043, 16'h0041, 16'h003F, 16'h003D, 16'h002B, 16'h0035, 16'h0067,
      16'h0069, 16'h00E2, 16'h00E1, 16'h0088, 16'h00E0, 16'h0014, 16'h001E, 16'h0000,
      16'h006A, 16'h0000, 16'h001D, 16'h0016, 16'h0004, 16'h001A, 16'h001F, 16'h0000,
      16'h006B, 16'h0006, 16'h001B, 16'h0007, 16'h0008, 16'h0021, 16'h0020, 16'h008C,
      16'h006C, 16'h002C, 16'h0019, 16'h0009, 16'h0017, 16'h0015, 16'h0022, 16'h0000,
      16'h006D, 16'h0011, 16'h0005, 16'h000B, 16'h000A, 16'h001C, 16'h0023, 16'h0000,
      16'h006E, 16'h0000, 16'h0010, 16'h000D, 16'h0018, 16'h0024, 16'h0025, 16'h0000,
      16'h006F, 16'h0036, 16'h000E, 16'h000C, 16'h0012, 16'h0027, 16'h0026, 16'h0000,
      16'h0070, 16'h0037, 16'h0038, 16'h000F, 16'h0033, 16'h0013, 16'h002D, 16'h0000,
      16'h0071, 16'h0087, 16'h0034, 16'h0000, 16'h002F, 16'h002E, 16'h0000, 16'h0072,
      16'h0039, 16'h00E5, 16'h0028, 16'h0030, 16'h0000, 16'h0031, 16'h0000, 16'h0073,
      16'h0000, 16'h0064, 16'h0093, 16'h0092, 16'h008A, 16'h0000, 16'h002A, 16'h008B,
      16'h0000, 16'h0059, 16'h0089, 16'h005C, 16'h005F, 16'h0085, 16'h0000, 16'h0000,
      16'h0062, 16'h0063, 16'h005A, 16'h005D, 16'h005E, 16'h0060, 16'h0029, 16'h0053,
      16'h0044, 16'h0057, 16'h005B, 16'h0056, 16'h0055, 16'h0061, 16'h0047, 16'h0046,
      16'h0000, 16'h0000, 16'h0000, 16'h0040, 16'h0046, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'hC221, 16'h00E6, 16'h0000, 16'h0000, 16'h00E4, 16'hC0B6, 16'h0000, 16'h0000,
      16'hC22A, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h00E3,
      16'hC227, 16'hC0EA, 16'h0000, 16'hC0E2, 16'h0000, 16'h0000, 16'h0000, 16'h00E7,
      16'hC226, 16'h0000, 16'h0000, 16'hC192, 16'h0000, 16'h0000, 16'h0000, 16'h0065,
      16'hC225, 16'h0000, 16'hC0E9, 16'h0000, 16'hC0CD, 16'h0000, 16'h0000, 16'h1081,
      16'hC224, 16'h0000, 16'hC223, 16'hC0B7, 16'h0000, 16'h0000, 16'h0000, 16'h1082,
      16'hC194, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'hC18A, 16'h0000, 16'h0054, 16'h0000, 16'h0000, 16'hC0B5, 16'h0000, 16'h0000,
      16'hC183, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0058, 16'h0000, 16'h0000, 16'h0000, 16'h1083, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h004D, 16'h0000, 16'h0050, 16'h004A, 16'h0000, 16'h0000, 16'h0000,
      16'h0049, 16'h004C, 16'h0051, 16'h0000, 16'h004F, 16'h0052, 16'h0000, 16'h0048,
      16'h0000, 16'h0000, 16'h004E, 16'h0000, 16'h0046, 16'h004B, 16'h0048, 16'h0000
    };
  end

  function automatic logic is_plain_code(input logic [ByteW-1:0] b);
    return (b < CODE_EXT_BIT) || (b == CODE_F7) || (b == CODE_SYSRQ);
  endfunction

  function automatic key_result_t key_event(input logic [ByteW-1:0] idx, input logic make);
    key_result_t r;
    r = '0;
    r.event_valid = 1'b1;
    r.is_make = make;
    {r.usage_page, r.usage_id} = usage_table[idx];
    return r;
  endfunction

  function automatic key_result_t translate_scan_byte(input logic [ByteW-1:0] b);
    key_result_t   r;
    prefix_state_t nxt;
    r = '0;
    nxt = ST_IDLE;
    case (key_prefix)
      ST_IDLE: begin
        if (b == CODE_E0) nxt = ST_E0;
        else if (b == CODE_F0) nxt = ST_F0;
        else if (b == CODE_E1) nxt = ST_E1;
        else if (is_plain_code(b)) r = key_event(b, 1'b1);
        else if (b != CODE_KOR_1 && b != CODE_KOR_2) r.decode_error = 1'b1;
      end
      ST_F0: begin
        if (is_plain_code(b)) r = key_event(b, 1'b0);
        else r.decode_error = 1'b1;
      end
      ST_E0, ST_E0_F0: begin
        if (b != CODE_LSHIFT && b != CODE_RSHIFT) begin
          if (key_prefix == ST_E0 && b == CODE_F0) nxt = ST_E0_F0;
          else if (b < CODE_EXT_BIT) r = key_event(b | CODE_EXT_BIT, key_prefix == ST_E0);
          else r.decode_error = 1'b1;
        end
      end
      ST_E1: begin
        if (b == CODE_LCTRL) nxt = ST_E1_14;
        else if (b == CODE_F0) nxt = ST_E1_F0;
      end
      ST_E1_14: begin
        if (b == CODE_NUMLK) r = key_event(CODE_NUMLK | CODE_EXT_BIT, 1'b1);
      end
      ST_E1_F0: begin
        if (b == CODE_LCTRL) nxt = ST_E1_F0_14;
      end
      ST_E1_F0_14: begin
        if (b == CODE_F0) nxt = ST_E1_F0_14_F0;
      end
      ST_E1_F0_14_F0: begin
        if (b == CODE_NUMLK) r = key_event(CODE_NUMLK | CODE_EXT_BIT, 1'b0);
      end
      default: nxt = ST_IDLE;
    endcase
    key_prefix = nxt;
    return r;
  endfunction

  always @(posedge clk) begin
    key_result_t got;
    key_result_t want;
    if (!rst_n) begin
      key_prefix = ST_IDLE;
      expected_keys.delete();
    end else begin
      if (in_valid && !in_stall) expected_keys.push_back(translate_scan_byte(in_scan_byte));
      if (out_valid && !out_stall) begin
        got = {out_event_valid, out_is_make, out_usage_page, out_usage_id, out_decode_error};
        if (expected_keys.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none expected, got ev=%0b make=%0b page=%h id=%h err=%0b",
                   $time, got.event_valid, got.is_make, got.usage_page, got.usage_id,
                   got.decode_error);
        end else begin
          want = expected_keys.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: expected ev=%0b make=%0b page=%h id=%h err=%0b", $time,
                     want.event_valid, want.is_make, want.usage_page, want.usage_id,
                     want.decode_error);
            $display("%0t:   actual ev=%0b make=%0b page=%h id=%h err=%0b", $time,
                     got.event_valid, got.is_make, got.usage_page, got.usage_id,
                     got.decode_error);
          end
        end
      end
    end
    fail_count <= mismatches;
    pending_count <= expected_keys.size();
  end

endmodule

>>> dv/scan_code_set2_to_hid_translator_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the Set 2 scan code to HID usage translator.
// Drives scan byte sequences with random gaps and result stalls and gives the verdict.
// Depends on sc2h_pkg, scan_code_set2_to_hid_translator_top and sc2h_result_checker.
module scan_code_set2_to_hid_translator_top_tb;
  import sc2h_pkg::*;

  localparam int unsigned NumBytes  = 600;
  localparam int unsigned IdleLimit = 1000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [ByteW-1:0] in_scan_byte;
  logic             out_valid;
  logic             out_stall;
  logic             out_event_valid;
  logic             out_is_make;
  logic [PageW-1:0] out_usage_page;
  logic [IdW-1:0]   out_usage_id;
  logic             out_decode_error;
  int               fail_count;
  int               pending_count;
  int               idle_cycles = 0;
  int               bytes_sent = 0;
  logic             in_burst = 1'b0;

  scan_code_set2_to_hid_translator_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_scan_byte     (in_scan_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_valid  (out_event_valid),
    .out_is_make      (out_is_make),
    .out_usage_page   (out_usage_page),
    .out_usage_id     (out_usage_id),
    .out_decode_error (out_decode_error)
  );

  sc2h_result_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_scan_byte     (in_scan_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_valid  (out_event_valid),
    .out_is_make      (out_is_make),
    .out_usage_page   (out_usage_page),
    .out_usage_id     (out_usage_id),
    .out_decode_error (out_decode_error),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  always #5 clk = ~clk;

  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_scan_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [ByteW-1:0] random_plain_code();
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1) ? CODE_F7 : CODE_SYSRQ;
    return ByteW'($urandom_range(0, 127));
  endfunction

  task automatic send_random_sequence();
    int kind;
    int pick;
    int tail;
    if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      send_byte(random_plain_code());
    end else if (kind < 50) begin
      send_byte(CODE_F0);
      send_byte(($urandom_range(0, 7) == 0) ? ByteW'($urandom_range(0, 255)) : random_plain_code());
    end else if (kind < 70) begin
      send_byte(CODE_E0);
      if ($urandom_range(0, 1)) send_byte(CODE_F0);
      pick = $urandom_range(0, 9);
      if (pick == 0) send_byte(CODE_LSHIFT);
      else if (pick == 1) send_byte(CODE_RSHIFT);
      else if (pick == 2) send_byte(ByteW'($urandom_range(0, 255)));
      else send_byte(ByteW'($urandom_range(0, 127)));
    end else if (kind < 76) begin
      send_byte(CODE_E1);
      send_byte(CODE_LCTRL);
      send_byte(CODE_NUMLK);
    end else if (kind < 82) begin
      send_byte(CODE_E1);
      send_byte(CODE_F0);
      send_byte(CODE_LCTRL);
      send_byte(CODE_F0);
      send_byte(CODE_NUMLK);
    end else if (kind < 88) begin
      send_byte(CODE_E1);
      tail = $urandom_range(1, 4);
      repeat (tail) begin
        pick = $urandom_range(0, 3);
        if (pick == 0) send_byte(CODE_LCTRL);
        else if (pick == 1) send_byte(CODE_F0);
        else if (pick == 2) send_byte(CODE_NUMLK);
        else send_byte(ByteW'($urandom_range(0, 255)));
      end
    end else begin
      send_byte(ByteW'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    logic [ByteW-1:0] directed_seq [$];
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_scan_byte <= '0;
    directed_seq = {CODE_F7,
                    CODE_F0, CODE_SYSRQ,
                    CODE_F0, 8'hFF,
                    CODE_E0, 8'h7F,
                    CODE_E0, CODE_F0, 8'h00,
                    CODE_E0, CODE_LSHIFT,
                    CODE_E0, CODE_F0, CODE_RSHIFT,
                    CODE_E0, CODE_EXT_BIT,
                    CODE_KOR_1, CODE_KOR_2, 8'hAA,
                    CODE_E1, CODE_LCTRL, CODE_NUMLK,
                    CODE_E1, CODE_F0, CODE_LCTRL, CODE_F0, CODE_NUMLK,
                    CODE_E1, 8'h00};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_seq[i]) send_byte(directed_seq[i]);
    while (bytes_sent < NumBytes) send_random_sequence();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("scan_code_set2_to_hid_translator_top test passed");
    end else begin
      $display("scan_code_set2_to_hid_translator_top test failed");
    end
    $finish;
  end

  initial begin : result_stall
    int   hold;
    int   results_seen;
    logic out_burst;
    results_seen = 0;
    out_burst = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (results_seen % 40 == 0) out_burst = ($urandom_range(0, 3) == 0);
      hold = out_burst ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("scan_code_set2_to_hid_translator_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> scan_code_set2_to_hid_translator_top.f
hw/rtl/sc2h_pkg.sv
hw/rtl/sc2h_decode.sv
hw/rtl/scan_code_set2_to_hid_translator_top.sv
dv/sc2h_result_checker.sv
dv/scan_code_set2_to_hid_translator_top_tb.sv
